// ===== design/sphc_pkg.sv =====
// sphc_pkg: widths, codes, pipeline types and step functions for sphere_pair_contact
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sphc_pkg;

    localparam int CoordW    = 31;
    localparam int DiffW     = 32;
    localparam int RadW      = 29;
    localparam int CntW      = 16;
    localparam int SumW      = 30;
    localparam int SumSqW    = 60;
    localparam int SqW       = 64;
    localparam int DistW     = 32;
    localparam int KmW       = 31;
    localparam int ProdW     = 63;
    localparam int QuoW      = 31;
    localparam int DenW      = 33;
    localparam int NormW     = 18;
    localparam int NormFrac  = 16;
    localparam int PointW    = 32;
    localparam int DepthW    = 30;
    localparam int Lanes     = 6;

    localparam int SqrtSteps = 32;
    localparam int DivSteps  = QuoW;

    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    // stream payload layout
    localparam int InW      = 264;
    localparam int OutW     = 184;
    localparam int RaLsb    = 6 * CoordW;
    localparam int RbLsb    = RaLsb + RadW;
    localparam int ExLsb    = RbLsb + RadW;

    // configuration register indexes
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_CONTACT_ENABLE = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_CONTACTS   = 1'd1;

    localparam logic [CntW-1:0] MAX_CONTACTS_RST = 16'd1000;
    localparam logic [NormW-1:0] NORM_ONE = 18'd65536;

    // classified pair handed from the front to the back
    typedef struct packed {
        logic                         coll;
        logic                         cval;
        logic [2:0][CoordW-1:0]       a;
        logic [2:0]                   dpos;
        logic [2:0][DiffW-1:0]        dmag;
        logic [SqW-1:0]               dsq;
        logic [SumW-1:0]              sum;
        logic [RadW-1:0]              ra;
    } t_job;

    // square root pipeline word
    typedef struct packed {
        t_job             job;
        logic [SqW-1:0]   v;
        logic [SqW-1:0]   r;
    } t_sq;

    // context after the distance is known
    typedef struct packed {
        logic                         coll;
        logic                         cval;
        logic [2:0][CoordW-1:0]       a;
        logic [2:0]                   dpos;
        logic [2:0][DiffW-1:0]        dmag;
        logic [DepthW-1:0]            depth;
        logic [DistW-1:0]             dlen;
        logic [KmW-1:0]               km;
        logic                         kneg;
        logic                         dzero;
    } t_ctx;

    typedef struct packed {
        t_ctx                         ctx;
        logic [2:0][ProdW-1:0]        prod;
    } t_prod;

    // six dividers: lanes 0..2 normal, lanes 3..5 point offset
    typedef struct packed {
        t_ctx                         ctx;
        logic [DenW-1:0]              den;
        logic [Lanes-1:0][SqW-1:0]    rem;
        logic [Lanes-1:0][QuoW-1:0]   quo;
    } t_dv;

    // one digit of the bitwise integer square root
    function automatic t_sq sqrt_step(t_sq x, int sh);
        t_sq          y;
        logic [SqW:0] trial;
        logic [SqW-1:0] bitv;
        bitv  = SqW'(1) << sh;
        trial = {1'b0, x.r} + {1'b0, bitv};
        y     = x;
        if ({1'b0, x.v} >= trial) begin
            y.v = x.v - trial[SqW-1:0];
            y.r = (x.r >> 1) + bitv;
        end else begin
            y.r = x.r >> 1;
        end
        return y;
    endfunction

    // one quotient bit of a restoring division on every lane
    function automatic t_dv div_step(t_dv x, int j);
        t_dv            y;
        logic [SqW-1:0] sh;
        sh = SqW'(x.den) << j;
        y  = x;
        for (int l = 0; l < Lanes; l++) begin
            if (x.rem[l] >= sh) begin
                y.rem[l]    = x.rem[l] - sh;
                y.quo[l][j] = 1'b1;
            end
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== design/sphc_front.sv =====
// sphc_front: input transfer, center offsets, squares and overlap classification
// also holds the two configuration registers; depends on sphc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sphc_front import sphc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // ax, ay, az, bx, by, bz, radius_a, radius_b, existing_contacts, zero pad
    input  logic [InW-1:0]      s_axis_tdata,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CntW-1:0]     i_cfg_data,
    output logic                o_push,
    output t_job                o_job,
    input  logic                i_full
);

    logic            r_cen;
    logic [CntW-1:0] r_max;

    logic adv;

    logic                   r_v1, r_v2, r_v3, r_v4;
    logic [2:0][CoordW-1:0] r_a1, r_b1, r_a2, r_a3, r_a4;
    logic [RadW-1:0]        r_ra1, r_rb1, r_ra2, r_ra3, r_ra4;
    logic [CntW-1:0]        r_ex1, r_ex2;
    logic [2:0]             r_dpos2, r_dpos3, r_dpos4;
    logic [2:0][DiffW-1:0]  r_dmag2, r_dmag3, r_dmag4;
    logic [SumW-1:0]        r_sum2, r_sum3, r_sum4;
    logic [2:0][SqW-1:0]    r_sq3;
    logic [SumSqW-1:0]      r_sumsq3, r_sumsq4;
    logic                   r_ge3, r_ge4;
    logic [SqW-1:0]         r_dsq4;

    logic [2:0][DiffW-1:0]  n_d;
    logic [2:0]             n_dpos;
    logic [2:0][DiffW-1:0]  n_dmag;
    logic                   ovl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen <= 1'b1;
            r_max <= MAX_CONTACTS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CONTACT_ENABLE: r_cen <= i_cfg_data[0];
                CFG_MAX_CONTACTS:   r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign adv           = !r_v4 || !i_full;
    assign s_axis_tready = adv;
    assign o_push        = r_v4 && !i_full;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i]    = {r_b1[i][CoordW-1], r_b1[i]} - {r_a1[i][CoordW-1], r_a1[i]};
            n_dpos[i] = !n_d[i][DiffW-1] && (n_d[i] != '0);
            n_dmag[i] = n_d[i][DiffW-1] ? (~n_d[i] + DiffW'(1)) : n_d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_a1[i] <= s_axis_tdata[i*CoordW +: CoordW];
                r_b1[i] <= s_axis_tdata[(i+3)*CoordW +: CoordW];
            end
            r_ra1 <= s_axis_tdata[RaLsb +: RadW];
            r_rb1 <= s_axis_tdata[RbLsb +: RadW];
            r_ex1 <= s_axis_tdata[ExLsb +: CntW];

            r_a2    <= r_a1;
            r_dpos2 <= n_dpos;
            r_dmag2 <= n_dmag;
            r_sum2  <= SumW'(r_ra1) + SumW'(r_rb1);
            r_ra2   <= r_ra1;
            r_ex2   <= r_ex1;

            r_a3    <= r_a2;
            r_dpos3 <= r_dpos2;
            r_dmag3 <= r_dmag2;
            for (int i = 0; i < 3; i++) begin
                r_sq3[i] <= r_dmag2[i] * r_dmag2[i];
            end
            r_sumsq3 <= r_sum2 * r_sum2;
            r_sum3   <= r_sum2;
            r_ra3    <= r_ra2;
            r_ge3    <= r_ex2 >= r_max;

            r_a4     <= r_a3;
            r_dpos4  <= r_dpos3;
            r_dmag4  <= r_dmag3;
            r_dsq4   <= r_sq3[0] + r_sq3[1] + r_sq3[2];
            r_sumsq4 <= r_sumsq3;
            r_sum4   <= r_sum3;
            r_ra4    <= r_ra3;
            r_ge4    <= r_ge3;
        end
    end

    assign ovl = r_dsq4 <= SqW'(r_sumsq4);

    always_comb begin
        o_job.a    = r_a4;
        o_job.dpos = r_dpos4;
        o_job.dmag = r_dmag4;
        o_job.dsq  = r_dsq4;
        o_job.sum  = r_sum4;
        o_job.ra   = r_ra4;
        if (r_max == '0) begin
            o_job.coll = 1'b0;
            o_job.cval = 1'b0;
        end else if (!r_cen) begin
            o_job.coll = ovl;
            o_job.cval = 1'b0;
        end else if (r_ge4) begin
            o_job.coll = 1'b0;
            o_job.cval = 1'b0;
        end else begin
            o_job.coll = ovl;
            o_job.cval = ovl;
        end
    end

endmodule

`default_nettype wire

// ===== design/sphc_queue.sv =====
// sphc_queue: short fifo of classified pairs between front and back
// depends on sphc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sphc_queue import sphc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job             r_mem [QueueDepth];
    logic [QPtrW-1:0] r_wr, r_rd;
    logic [QCntW-1:0] r_cnt;

    assign o_job   = r_mem[r_rd];
    assign o_empty = r_cnt == '0;
    assign o_full  = r_cnt == QCntW'(QueueDepth);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPtrW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPtrW'(1);
            end
            r_cnt <= r_cnt + QCntW'(i_push) - QCntW'(i_pop);
        end
    end

endmodule

`default_nettype wire

// ===== design/sphc_sqrt.sv =====
// sphc_sqrt: pipelined integer square root of the squared center distance
// one result bit per stage; depends on sphc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sphc_sqrt import sphc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_job             i_job,
    output logic             o_vld,
    output t_job             o_job,
    output logic [DistW-1:0] o_dist
);

    t_sq                  st_in  [SqrtSteps];
    t_sq                  st_out [SqrtSteps];
    t_sq                  r_st   [SqrtSteps];
    logic [SqrtSteps-1:0] r_vld;

    assign st_in[0] = '{job: i_job, v: i_job.dsq, r: '0};

    for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
        if (s > 0) begin : g_link
            assign st_in[s] = r_st[s-1];
        end
        assign st_out[s] = sqrt_step(st_in[s], 2 * (SqrtSteps - 1 - s));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < SqrtSteps; s++) begin
                r_st[s] <= st_out[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SqrtSteps-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[SqrtSteps-1];
    assign o_job  = r_st[SqrtSteps-1].job;
    assign o_dist = r_st[SqrtSteps-1].r[DistW-1:0];

endmodule

`default_nettype wire

// ===== design/sphc_solve.sv =====
// sphc_solve: depth, pipelined divisions for normal and point, saturation, output register
// depends on sphc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sphc_solve import sphc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_job             i_job,
    input  logic [DistW-1:0] i_dist,
    output logic             o_valid,
    output logic [OutW-1:0]  o_data,
    output logic             o_user
);

    localparam int Chain = DivSteps + 3;

    t_ctx              n_c1, r_c1;
    t_prod             r_p2;
    t_dv               n_dv0;
    t_dv               dv_in  [DivSteps];
    t_dv               dv_out [DivSteps];
    t_dv               r_dv   [DivSteps + 1];
    logic [Chain-1:0]  r_vld;

    logic [DiffW-1:0]  k;

    logic [2:0][NormW-1:0]  res_n;
    logic [2:0][PointW-1:0] res_p;
    logic [QuoW-1:0]        om;
    logic [PointW:0]        pa, off, ps;
    logic [NormW-1:0]       nm;
    t_ctx                   fc;
    logic                   r_out_v;
    logic [OutW-1:0]        r_out_d;
    logic                   r_out_u;

    // depth and the offset factor depth - 2*ra
    always_comb begin
        n_c1.coll  = i_job.coll;
        n_c1.cval  = i_job.cval;
        n_c1.a     = i_job.a;
        n_c1.dpos  = i_job.dpos;
        n_c1.dmag  = i_job.dmag;
        n_c1.dlen  = i_dist;
        n_c1.dzero = i_dist == '0;
        n_c1.depth = i_job.sum - i_dist[DepthW-1:0];
        k          = {2'b00, n_c1.depth} - {2'b00, i_job.ra, 1'b0};
        n_c1.kneg  = k[DiffW-1];
        n_c1.km    = k[DiffW-1] ? KmW'(~k + DiffW'(1)) : k[KmW-1:0];
    end

    // dividend setup: normal = (2*d*65536 + dist) / (2*dist), offset = (d*km + dist) / (2*dist)
    always_comb begin
        n_dv0.ctx = r_p2.ctx;
        n_dv0.den = {r_p2.ctx.dlen, 1'b0};
        n_dv0.quo = '0;
        for (int i = 0; i < 3; i++) begin
            n_dv0.rem[i]   = SqW'({r_p2.ctx.dmag[i], {(NormFrac + 1){1'b0}}})
                             + SqW'(r_p2.ctx.dlen);
            n_dv0.rem[i+3] = SqW'(r_p2.prod[i]) + SqW'(r_p2.ctx.dlen);
        end
    end

    for (genvar s = 0; s < DivSteps; s++) begin : g_div
        assign dv_in[s]  = r_dv[s];
        assign dv_out[s] = div_step(dv_in[s], DivSteps - 1 - s);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1      <= n_c1;
            r_p2.ctx  <= r_c1;
            for (int i = 0; i < 3; i++) begin
                r_p2.prod[i] <= r_c1.dmag[i] * r_c1.km;
            end
            r_dv[0] <= n_dv0;
            for (int s = 0; s < DivSteps; s++) begin
                r_dv[s+1] <= dv_out[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Chain-2:0], i_vld};
        end
    end

    // signs, coincident centers, saturation
    always_comb begin
        fc = r_dv[DivSteps].ctx;
        for (int i = 0; i < 3; i++) begin
            nm = NormW'(r_dv[DivSteps].quo[i][NormFrac:0]);
            res_n[i] = fc.dpos[i] ? (~nm + NormW'(1)) : nm;
            om = r_dv[DivSteps].quo[i+3];
            if (fc.dmag[i] == '0 || fc.km == '0) begin
                om = '0;
            end
            pa  = {{2{fc.a[i][CoordW-1]}}, fc.a[i]};
            off = {2'b00, om};
            ps  = (fc.dpos[i] ^ fc.kneg) ? (pa - off) : (pa + off);
            if (ps[PointW] != ps[PointW-1]) begin
                res_p[i] = ps[PointW] ? {1'b1, {(PointW-1){1'b0}}}
                                      : {1'b0, {(PointW-1){1'b1}}};
            end else begin
                res_p[i] = ps[PointW-1:0];
            end
            if (fc.dzero) begin
                res_p[i] = {fc.a[i][CoordW-1], fc.a[i]};
            end
        end
        if (fc.dzero) begin
            res_n = {NORM_ONE, {NormW{1'b0}}, {NormW{1'b0}}};
        end
        if (!fc.cval) begin
            res_n = '0;
            res_p = '0;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out_d;
    assign o_user  = r_out_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_vld[Chain-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_u <= fc.cval;
            r_out_d <= {3'b000,
                        fc.cval ? fc.depth : {DepthW{1'b0}},
                        res_n[2], res_n[1], res_n[0],
                        res_p[2], res_p[1], res_p[0],
                        fc.coll};
        end
    end

endmodule

`default_nettype wire

// ===== design/sphere_pair_contact.sv =====
// sphere_pair_contact: sphere pair overlap test with one contact per pair
// throughput: one pair per cycle while m_axis_tready does not stall the back pipeline,
// which holds the 32-stage square root and the 31-stage dividers
// a four-entry queue separates the classifying front from the arithmetic back
// reset (i_rst_n low, synchronous) empties every stage; contact_enable=1, max_contacts=1000
`timescale 1ns / 1ps
`default_nettype none

module sphere_pair_contact import sphc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // center_a_x, center_a_y, center_a_z, center_b_x, center_b_y, center_b_z,
    // radius_a, radius_b, existing_contacts, zero pad
    input  logic [InW-1:0]      s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // collided, point_x, point_y, point_z, normal_x, normal_y, normal_z, depth, zero pad
    output logic [OutW-1:0]     m_axis_tdata,
    // contact_valid
    output logic                m_axis_tuser,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CntW-1:0]     i_cfg_data
);

    logic             push, full, empty, pop, back_en;
    t_job             front_job, queue_job, sqrt_job;
    logic             sqrt_vld;
    logic [DistW-1:0] sqrt_dist;

    sphc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (push),
        .o_job         (front_job),
        .i_full        (full)
    );

    sphc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (empty),
        .o_full  (full)
    );

    // back pipeline moves whenever the output register can take a transfer
    assign back_en = !m_axis_tvalid || m_axis_tready;
    assign pop     = back_en && !empty;

    sphc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_vld   (pop),
        .i_job   (queue_job),
        .o_vld   (sqrt_vld),
        .o_job   (sqrt_job),
        .o_dist  (sqrt_dist)
    );

    sphc_solve u_solve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_vld   (sqrt_vld),
        .i_job   (sqrt_job),
        .i_dist  (sqrt_dist),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== design/sphc_check.sv =====
// sphc_check: port-level checks on the result stream of sphere_pair_contact
// bound to the top level; depends on sphc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sphc_check import sphc_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            m_axis_tvalid,
    input logic            m_axis_tready,
    input logic [OutW-1:0] m_axis_tdata,
    input logic            m_axis_tuser
);

    // a contact is only reported on a collision
    a_contact_implies_coll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[0])
        else $error("contact without collision");

    // without a contact, point, normal and depth are all zero
    a_no_contact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OutW-1:1] == '0)
        else $error("nonzero contact fields without contact");

    // a stalled result transfer holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed under stall");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sphere_pair_contact sphc_check u_sphc_check (.*);

`default_nettype wire
